// ===== design/bft_pkg.sv =====
// Shared types and constants for the bidirectional flow table.
package bft_pkg;

  localparam int FLOW_ENTRIES_DEF = 64;
  localparam int MAX_PACKETS_DEF  = 16;
  localparam int INDEX_W          = 6;
  localparam int COUNT_W          = 5;

  // Input beat
  typedef struct packed {
    logic [7:0]  proto_num;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] pay_len;
    logic [31:0] timestamp;
  } pkt_in_t;

  // Result beat
  typedef struct packed {
    logic                hit;
    logic [INDEX_W-1:0]  flow_index;
    logic [COUNT_W-1:0]  packet_count;
    logic                logged;
    logic                table_full;
  } pkt_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // capture input beat, reset scan pointer
    logic rd;       // issue table read at scan pointer
    logic adv;      // advance scan pointer
    logic update;   // count update on hit, and log write while below the limit
    logic alloc;    // allocate new entry
    logic drop;     // table full result
    logic done;     // emit result
  } bft_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic match;    // registered read entry matched
    logic last;     // pointer at final scanned entry
    logic empty;    // nothing to scan
    logic full;     // no free entry
  } bft_sts_t;

endpackage

// ===== design/bft_ctrl.sv =====
// Controller state machine for the flow table search.
module bft_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output bft_pkg::bft_cmd_t cmd,
  input  bft_pkg::bft_sts_t sts
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_MISS  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (sts.empty) begin
          state_next = S_MISS;
        end else begin
          cmd.rd = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.match) begin
          cmd.update = 1'b1;
          state_next = S_DONE;
        end else if (sts.last) begin
          state_next = S_MISS;
        end else begin
          cmd.adv = 1'b1;
          state_next = S_READ;
        end
      end
      S_MISS: begin
        if (sts.full) cmd.drop = 1'b1;
        else          cmd.alloc = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.done = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  // A result leaves only from the done state
  a_done_state: assert property (@(posedge clk) disable iff (rst)
    cmd.done |-> state == S_DONE) else $error("done outside done state");
  // Update and allocate never coincide
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.update && cmd.alloc)) else $error("update and alloc together");
  // Done follows a decision
  a_done_after: assert property (@(posedge clk) disable iff (rst)
    cmd.done |-> $past(state) == S_CMP || $past(state) == S_MISS)
    else $error("done without decision");

endmodule

// ===== design/bft_dp.sv =====
// Datapath: key register, flow table memories, scan pointer and log memories.
module bft_dp #(
  parameter int FLOW_ENTRIES = bft_pkg::FLOW_ENTRIES_DEF,
  parameter int MAX_PACKETS  = bft_pkg::MAX_PACKETS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  bft_pkg::pkt_in_t  pkt_in,
  input  bft_pkg::bft_cmd_t cmd,
  output bft_pkg::bft_sts_t sts,
  output logic              strobe,
  output bft_pkg::pkt_out_t result
);

  localparam int IW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int UW = $clog2(FLOW_ENTRIES + 1);
  localparam int CW = $clog2(MAX_PACKETS + 1);
  localparam int SW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
  localparam int LOG_DEPTH = FLOW_ENTRIES * MAX_PACKETS;
  localparam int LW = $clog2(LOG_DEPTH);

  // Flow table storage
  logic [63:0]   addrs_mem [FLOW_ENTRIES];
  logic [39:0]   pp_mem    [FLOW_ENTRIES];
  logic [CW-1:0] cnt_mem   [FLOW_ENTRIES];
  logic [15:0]   size_log  [LOG_DEPTH];
  logic [31:0]   time_log  [LOG_DEPTH];

  bft_pkg::pkt_in_t key;
  logic [IW-1:0] ptr;
  logic [UW-1:0] used;
  logic [63:0]   rd_addrs;
  logic [39:0]   rd_pp;
  logic [CW-1:0] rd_cnt;

  // Captured beat and scan pointer
  always_ff @(posedge clk) begin
    if (cmd.load) key <= pkt_in;
    if (rst || cmd.load) ptr <= '0;
    else if (cmd.adv)    ptr <= ptr + 1'b1;
  end

  // Registered table read
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_addrs <= addrs_mem[ptr];
      rd_pp    <= pp_mem[ptr];
      rd_cnt   <= cnt_mem[ptr];
    end
  end

  // Match in either direction
  logic fwd, rev, at_limit;
  assign fwd = rd_addrs == {key.sip, key.dip} &&
               rd_pp == {key.proto_num, key.sport, key.dport};
  assign rev = rd_addrs == {key.dip, key.sip} &&
               rd_pp == {key.proto_num, key.dport, key.sport};
  assign at_limit = rd_cnt >= CW'(MAX_PACKETS);

  assign sts.match = fwd || rev;
  assign sts.last  = UW'(ptr) + 1'b1 >= used;
  assign sts.empty = used == '0;
  assign sts.full  = used >= UW'(FLOW_ENTRIES);

  logic [IW-1:0] wr_idx;
  logic [SW-1:0] wr_slot;
  logic          wr_log;
  assign wr_idx  = cmd.alloc ? used[IW-1:0] : ptr;
  assign wr_slot = cmd.alloc ? '0 : rd_cnt[SW-1:0];
  assign wr_log  = cmd.alloc || (cmd.update && !at_limit);

  // Table writes
  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      addrs_mem[wr_idx] <= {key.sip, key.dip};
      pp_mem[wr_idx]    <= {key.proto_num, key.sport, key.dport};
    end
    if (wr_log) cnt_mem[wr_idx] <= cmd.alloc ? CW'(1) : rd_cnt + 1'b1;
  end

  // Log writes
  always_ff @(posedge clk) begin
    if (wr_log) begin
      size_log[LW'(wr_idx) * LW'(MAX_PACKETS) + LW'(wr_slot)] <= key.pay_len;
      time_log[LW'(wr_idx) * LW'(MAX_PACKETS) + LW'(wr_slot)] <= key.timestamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)            used <= '0;
    else if (cmd.alloc) used <= used + 1'b1;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      result.hit          <= 1'b1;
      result.flow_index   <= bft_pkg::INDEX_W'(ptr);
      result.packet_count <= bft_pkg::COUNT_W'(at_limit ? rd_cnt : rd_cnt + 1'b1);
      result.logged       <= !at_limit;
      result.table_full   <= 1'b0;
    end else if (cmd.alloc) begin
      result.hit          <= 1'b0;
      result.flow_index   <= bft_pkg::INDEX_W'(used[IW-1:0]);
      result.packet_count <= bft_pkg::COUNT_W'(1);
      result.logged       <= 1'b1;
      result.table_full   <= 1'b0;
    end else if (cmd.drop) begin
      result.hit          <= 1'b0;
      result.flow_index   <= '0;
      result.packet_count <= '0;
      result.logged       <= 1'b0;
      result.table_full   <= 1'b1;
    end
  end

  assign strobe = cmd.done;

  // Fill count never exceeds the table
  a_used: assert property (@(posedge clk) disable iff (rst)
    used <= UW'(FLOW_ENTRIES)) else $error("fill count overflow");
  // No allocation into a full table
  a_alloc: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc |-> !sts.full) else $error("alloc when full");
  // Stored counts stay within the limit
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> rd_cnt <= CW'(MAX_PACKETS)) else $error("count over limit");

endmodule

// ===== design/bidirectional_flow_table.sv =====
// Bidirectional five-tuple flow table: search one header, then update, allocate or drop.
// Each used entry is scanned in turn through a read state and a compare state; a hit
// updates, a miss goes through a miss state that allocates or drops, then done strobes.
// One beat at a time: busy stays high through the strobe cycle, so the next beat goes in
// only once busy is low again. Reset clears the fill count and controller; table and log
// contents are undefined until written. The result is shown for one cycle; the receiver
// cannot stall.
module bidirectional_flow_table #(
  parameter int FLOW_ENTRIES = bft_pkg::FLOW_ENTRIES_DEF,
  parameter int MAX_PACKETS_PER_FLOW = bft_pkg::MAX_PACKETS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bft_pkg::pkt_in_t  pkt_in,
  output logic              strobe,
  output bft_pkg::pkt_out_t result
);

  bft_pkg::bft_cmd_t cmd;
  bft_pkg::bft_sts_t sts;

  bft_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
  );

  bft_dp #(.FLOW_ENTRIES(FLOW_ENTRIES), .MAX_PACKETS(MAX_PACKETS_PER_FLOW)) u_dp (
    .clk(clk), .rst(rst), .pkt_in(pkt_in), .cmd(cmd), .sts(sts),
    .strobe(strobe), .result(result)
  );

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the bidirectional flow table.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = bft_pkg::FLOW_ENTRIES_DEF;
  localparam int LIMIT   = bft_pkg::MAX_PACKETS_DEF;
  localparam int IDX_W   = bft_pkg::INDEX_W;
  localparam int CNT_W   = bft_pkg::COUNT_W;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              strobe;
  bft_pkg::pkt_in_t  pkt_in;
  bft_pkg::pkt_out_t result;

  bidirectional_flow_table DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pkt_in(pkt_in), .strobe(strobe), .result(result)
  );

  // Flow table mirror
  logic [31:0] fl_sa [ENTRIES];
  logic [31:0] fl_da [ENTRIES];
  logic [15:0] fl_sp [ENTRIES];
  logic [15:0] fl_dp [ENTRIES];
  logic [7:0]  fl_proto [ENTRIES];
  int          fl_count [ENTRIES];
  int          fl_used;

  bft_pkg::pkt_out_t pending_results[$];
  int       err_cnt;
  int       n_hits, n_full, n_limit, n_new;

  // Directed table: rows with a typed-in result set chk
  typedef struct {
    bft_pkg::pkt_in_t  pkt;
    bit                chk;
    bft_pkg::pkt_out_t res;
  } dir_row_t;
  dir_row_t dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  // Search, then update, allocate or report full; returns the expected result beat
  function automatic bft_pkg::pkt_out_t lookup_flow(bft_pkg::pkt_in_t p);
    bft_pkg::pkt_out_t r;
    bit fwd, rev;
    r = '0;
    for (int e = 0; e < fl_used; e++) begin
      fwd = fl_sa[e] == p.sip && fl_da[e] == p.dip &&
            fl_sp[e] == p.sport && fl_dp[e] == p.dport;
      rev = fl_sa[e] == p.dip && fl_da[e] == p.sip &&
            fl_sp[e] == p.dport && fl_dp[e] == p.sport;
      if (fl_proto[e] == p.proto_num && (fwd || rev)) begin
        r.hit = 1'b1;
        r.flow_index = e[IDX_W-1:0];
        if (fl_count[e] < LIMIT) begin
          fl_count[e]++;
          r.logged = 1'b1;
          n_hits++;
        end else n_limit++;
        r.packet_count = fl_count[e][CNT_W-1:0];
        return r;
      end
    end
    if (fl_used >= ENTRIES) begin
      r.table_full = 1'b1;
      n_full++;
      return r;
    end
    fl_sa[fl_used] = p.sip;
    fl_da[fl_used] = p.dip;
    fl_sp[fl_used] = p.sport;
    fl_dp[fl_used] = p.dport;
    fl_proto[fl_used] = p.proto_num;
    fl_count[fl_used] = 1;
    r.flow_index = fl_used[IDX_W-1:0];
    r.packet_count = CNT_W'(1);
    r.logged = 1'b1;
    fl_used++;
    n_new++;
    return r;
  endfunction

  // Result checker
  always @(posedge clk) begin
    bft_pkg::pkt_out_t exp_r;
    if (!rst && strobe) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        err_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result.hit !== exp_r.hit) begin
          $error("hit exp %0d got %0d", exp_r.hit, result.hit); err_cnt++;
        end
        if (result.flow_index !== exp_r.flow_index) begin
          $error("flow_index exp %0d got %0d", exp_r.flow_index, result.flow_index);
          err_cnt++;
        end
        if (result.packet_count !== exp_r.packet_count) begin
          $error("packet_count exp %0d got %0d", exp_r.packet_count,
                 result.packet_count);
          err_cnt++;
        end
        if (result.logged !== exp_r.logged) begin
          $error("logged exp %0d got %0d", exp_r.logged, result.logged); err_cnt++;
        end
        if (result.table_full !== exp_r.table_full) begin
          $error("table_full exp %0d got %0d", exp_r.table_full, result.table_full);
          err_cnt++;
        end
      end
    end
  end

  function automatic bft_pkg::pkt_out_t mk_res(bit h, int idx, int cnt, bit lg, bit full);
    bft_pkg::pkt_out_t r;
    r.hit = h;
    r.flow_index = idx[IDX_W-1:0];
    r.packet_count = cnt[CNT_W-1:0];
    r.logged = lg;
    r.table_full = full;
    return r;
  endfunction

  function automatic bft_pkg::pkt_in_t mk_pkt(logic [7:0] pr, logic [31:0] sa,
                                              logic [31:0] da, logic [15:0] sp,
                                              logic [15:0] dp);
    bft_pkg::pkt_in_t p;
    p.proto_num = pr;
    p.sip = sa;
    p.dip = da;
    p.sport = sp;
    p.dport = dp;
    p.pay_len = 16'($urandom);
    p.timestamp = $urandom;
    return p;
  endfunction

  function automatic bft_pkg::pkt_in_t rand_pkt();
    return mk_pkt(8'($urandom), $urandom, $urandom, 16'($urandom), 16'($urandom));
  endfunction

  // Send one beat: optional random gap, then hold start until accepted
  task automatic send_beat(bft_pkg::pkt_in_t p, bit use_gap);
    int gap;
    gap = 0;
    if (use_gap && $urandom_range(99) < 18) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    pkt_in <= p;
    // busy is settled mid-cycle; the beat goes in at the next rising edge once it is low
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    pending_results.push_back(lookup_flow(p));
    start <= 1'b0;
    pkt_in <= rand_pkt();
    @(posedge clk);
  endtask

  bft_pkg::pkt_in_t  known[$];
  bft_pkg::pkt_in_t  p;
  bft_pkg::pkt_out_t typed;
  int wait_cyc;

  initial begin
    rst = 1'b1;
    start = 1'b0;
    pkt_in = '0;
    err_cnt = 0;
    fl_used = 0;
    n_hits = 0; n_full = 0; n_limit = 0; n_new = 0;

    // Extremes, reverse-direction hit, protocol mismatch, limit reached
    dir_rows.push_back('{mk_pkt(8'h00, 32'h0, 32'h0, 16'h0, 16'h0), 1,
                         mk_res(0, 0, 1, 1, 0)});
    dir_rows.push_back('{mk_pkt(8'hff, '1, '1, '1, '1), 1, mk_res(0, 1, 1, 1, 0)});
    dir_rows.push_back('{mk_pkt(8'h06, 32'h0a000001, 32'hc0a80001, 16'd1234, 16'd80),
                         1, mk_res(0, 2, 1, 1, 0)});
    dir_rows.push_back('{mk_pkt(8'h06, 32'hc0a80001, 32'h0a000001, 16'd80, 16'd1234),
                         1, mk_res(1, 2, 2, 1, 0)});
    dir_rows.push_back('{mk_pkt(8'h11, 32'h0a000001, 32'hc0a80001, 16'd1234, 16'd80),
                         1, mk_res(0, 3, 1, 1, 0)});
    dir_rows.push_back('{mk_pkt(8'h06, 32'h0a000001, 32'hc0a80001, 16'd80, 16'd1234),
                         0, '0});
    for (int k = 0; k < 16; k++)
      dir_rows.push_back('{mk_pkt(8'hff, '1, '1, '1, '1), 0, '0});

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].pkt, 1'b0);
      if (dir_rows[i].chk) begin
        typed = pending_results[$];
        if (typed !== dir_rows[i].res) begin
          $error("directed row %0d: model %h table %h", i, typed, dir_rows[i].res);
          err_cnt++;
        end
      end
    end

    // Random: mostly repeats of known flows (either direction), some new flows
    for (int n = 0; n < 530; n++) begin
      if (known.size() > 0 && $urandom_range(99) < 65) begin
        p = known[$urandom_range(known.size() - 1)];
        if ($urandom_range(1))
          p = mk_pkt(p.proto_num, p.dip, p.sip, p.dport, p.sport);
        else
          p = mk_pkt(p.proto_num, p.sip, p.dip, p.sport, p.dport);
        if ($urandom_range(19) == 0) p.proto_num ^= 8'h01;
      end else begin
        p = rand_pkt();
        known.push_back(p);
      end
      send_beat(p, !(n >= 150 && n < 260));
    end
    start <= 1'b0;

    wait_cyc = 0;
    while (pending_results.size() != 0 && wait_cyc < 100000) begin
      @(posedge clk);
      wait_cyc++;
    end
    repeat (2 * ENTRIES + 10) @(posedge clk);

    $display("covered %0d new flows, %0d logged hits, %0d hits at limit, %0d full drops",
             n_new, n_hits, n_limit, n_full);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
